>>> rtl/nmf_pkg.sv
`default_nettype none

package nmf_pkg;

    // Geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS  = 11;
    localparam int IDX_BITS   = 8;
    localparam int MIN_COUNT  = 6;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ZERO_BORDER  = 2'd2;

    // Request kinds on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [IDX_BITS-1:0] t_index;

    typedef struct packed {
        logic   last;
        t_index idx;
    } t_result;

    // Zero reads as one, anything above the maximum saturates
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v,
                                                     input logic [SIZE_BITS-1:0] vmax);
        logic [SIZE_BITS-1:0] res;
        if (v == '0) begin
            res = SIZE_BITS'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Index held by at least MIN_COUNT of the eight neighbours, else zero.
    // Only one value can reach the count, so OR-ing the hits is safe.
    function automatic t_index majority(input logic [7:0][IDX_BITS-1:0] nb);
        t_index     res;
        logic [3:0] cnt;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            cnt = '0;
            for (int j = 0; j < 8; j++) begin
                cnt = cnt + {3'b000, (nb[j] == nb[i])};
            end
            if (cnt >= 4'(MIN_COUNT)) begin
                res = res | nb[i];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/neighbor_majority_filter_pass_top.sv
// 3x3 mode filter, one pass, over a raster stream of colour indices.
// Slave stream: tdata = in_index, tuser = request kind (0 pixel, 1 flush tick).
// Master stream: tdata = out_index, tlast = end of image (last flush result).
// Configuration: write enable, index (0 width, 1 height, 2 zero border) and
// data; the user writes it only while the block is idle (not enforced).
// A pixel request is taken every cycle while tready is high. Its memory read
// happens at acceptance, the filter and write-back in the next cycle, and its
// results enter an 8-entry output queue at that edge, so they show on the
// master side the cycle after. In image terms a result lags its pixel by one
// row and one pixel; after the last pixel, width flush ticks emit the last row.
// Throughput is one request per cycle, set by the single read and single
// write of the line store per cycle (a read-after-write on the same entry in
// adjacent cycles is forwarded). A pixel may give up to two results; tready
// drops when the queue has no room for the results of the two requests that
// can be in flight, so a stalled receiver stops the input, nothing lost.
// Reset (synchronous, active low) clears counters, window, queue and restores
// width 1024, height 1024, zero border off. The line store is not cleared.
`default_nettype none

module neighbor_majority_filter_pass_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_wdata,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,    // [7:0] in_index
    input  wire         s_axis_tuser,    // [0] operation
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_index
    output logic        m_axis_tlast     // end_of_image
);

    localparam int CB = nmf_pkg::COL_BITS;
    localparam int RB = nmf_pkg::ROW_BITS;
    localparam int SB = nmf_pkg::SIZE_BITS;
    localparam int IB = nmf_pkg::IDX_BITS;
    localparam int AW = nmf_pkg::FIFO_AW;

    // configuration registers
    logic [SB-1:0] r_cfg_width;
    logic [SB-1:0] r_cfg_height;
    logic          r_zero_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= SB'(nmf_pkg::MAX_WIDTH);
            r_cfg_height  <= SB'(nmf_pkg::MAX_HEIGHT);
            r_zero_border <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                nmf_pkg::REG_IMAGE_WIDTH:  r_cfg_width   <= i_cfg_wdata;
                nmf_pkg::REG_IMAGE_HEIGHT: r_cfg_height  <= i_cfg_wdata;
                nmf_pkg::REG_ZERO_BORDER:  r_zero_border <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [SB-1:0] w_eff;
    logic [SB-1:0] h_eff;
    assign w_eff = nmf_pkg::eff_size(r_cfg_width,  SB'(nmf_pkg::MAX_WIDTH));
    assign h_eff = nmf_pkg::eff_size(r_cfg_height, SB'(nmf_pkg::MAX_HEIGHT));

    // ---------------------------------------------------------------
    // Stage 0: accept, position counters, line store read
    // ---------------------------------------------------------------
    logic [CB-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [CB-1:0] r_flush_cnt;
    logic          r_flush_pend;

    logic          accept;
    logic          is_flush;
    logic          col_end;
    logic          row_end;
    logic          f_last;
    logic [CB-1:0] rd_addr;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign is_flush = (s_axis_tuser == nmf_pkg::OP_FLUSH);
    assign col_end  = ({1'b0, r_col} + SB'(1)) >= w_eff;
    assign row_end  = ({1'b0, r_row} + SB'(1)) >= h_eff;
    assign f_last   = ({1'b0, r_flush_cnt} + SB'(1)) >= w_eff;
    assign rd_addr  = is_flush ? r_flush_cnt : r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_flush_cnt  <= '0;
            r_flush_pend <= 1'b0;
        end else if (accept) begin
            if (is_flush) begin
                if (r_flush_pend && !f_last) begin
                    r_flush_cnt <= r_flush_cnt + CB'(1);
                end else begin
                    r_flush_cnt  <= '0;
                    r_flush_pend <= 1'b0;
                end
            end else begin
                r_flush_cnt  <= '0;
                r_flush_pend <= 1'b0;
                if (col_end) begin
                    r_col <= '0;
                    if (row_end) begin
                        r_row        <= '0;
                        r_flush_pend <= 1'b1;
                    end else begin
                        r_row <= r_row + RB'(1);
                    end
                end else begin
                    r_col <= r_col + CB'(1);
                end
            end
        end
    end

    // stage 1 request registers
    logic          r_s1_pix;
    logic          r_s1_flush;
    logic          r_s1_flast;
    logic          r_s1_ea;
    logic          r_s1_eb;
    logic          r_s1_int;
    logic          r_s1_ec;
    logic [CB-1:0] r_s1_addr;
    logic [IB-1:0] r_s1_v;
    logic          r_s1_fwd;
    logic [2*IB-1:0] r_s1_fwd_word;
    logic [2*IB-1:0] r_rdata;

    logic [2*IB-1:0] s1_word;
    logic [IB-1:0]   s1_u;
    logic [IB-1:0]   s1_m;
    logic            fwd_hit;

    assign s1_word = r_s1_fwd ? r_s1_fwd_word : r_rdata;
    assign s1_u    = s1_word[2*IB-1:IB];
    assign s1_m    = s1_word[IB-1:0];
    assign fwd_hit = accept & r_s1_pix & (rd_addr == r_s1_addr);

    // pixel flags, taken from the counters before they move
    logic n_ea, n_eb, n_int, n_ec;
    always_comb begin
        n_ea  = (r_col == '0) && (r_row >= RB'(2));
        n_eb  = (r_col != '0) && (r_row != '0);
        n_int = (r_row >= RB'(2)) && (r_col >= CB'(2)) &&
                ({1'b0, r_row} < h_eff) && ({1'b0, r_col} < w_eff);
        n_ec  = col_end && row_end && (r_row != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_s1_pix   <= accept & !is_flush;
            r_s1_flush <= accept & is_flush & r_flush_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flast    <= f_last;
            r_s1_ea       <= n_ea;
            r_s1_eb       <= n_eb;
            r_s1_int      <= n_int;
            r_s1_ec       <= n_ec;
            r_s1_addr     <= rd_addr;
            r_s1_v        <= s_axis_tdata;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_word <= {s1_m, r_s1_v};
        end
    end

    // line store: {upper, middle} per column, read-first
    logic [2*IB-1:0] line_mem [nmf_pkg::MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= line_mem[rd_addr];
        end
        if (r_s1_pix) begin
            line_mem[r_s1_addr] <= {s1_m, r_s1_v};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: window, filter, results
    // ---------------------------------------------------------------
    logic [IB-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_pix) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= s1_u;
            r_win[1] <= s1_m;
            r_win[2] <= r_s1_v;
        end
    end

    logic [7:0][IB-1:0] nb;
    logic [IB-1:0]      maj;
    logic [IB-1:0]      bord_ctr;
    logic [IB-1:0]      bord_m;
    nmf_pkg::t_result   res0;
    nmf_pkg::t_result   res1;
    logic [1:0]         push_n;

    assign nb       = {r_s1_v, s1_m, s1_u, r_win[2], r_win[0], r_win[5], r_win[4], r_win[3]};
    assign maj      = nmf_pkg::majority(nb);
    assign bord_ctr = r_zero_border ? '0 : r_win[1];
    assign bord_m   = r_zero_border ? '0 : s1_m;

    // results in order: previous row end, this window, image end
    always_comb begin
        res0   = '{last: 1'b0, idx: bord_m};
        res1   = '{last: 1'b0, idx: bord_m};
        push_n = 2'd0;
        if (r_s1_flush) begin
            res0   = '{last: r_s1_flast, idx: bord_m};
            push_n = 2'd1;
        end else if (r_s1_pix) begin
            if (r_s1_ea) begin
                res0 = '{last: 1'b0, idx: bord_ctr};
            end else if (r_s1_eb) begin
                res0 = '{last: 1'b0, idx: (r_s1_int ? maj : bord_ctr)};
            end
            push_n = 2'({1'b0, r_s1_ea} + {1'b0, r_s1_eb} + {1'b0, r_s1_ec});
        end
    end

    // ---------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------
    nmf_pkg::t_result r_fifo [nmf_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             pop;

    assign pop = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + (AW+1)'(push_n) - (AW+1)'(pop);
        end
    end

    // room for two results from stage 1 and two from a new request
    logic [AW+1:0] need;
    assign need = {1'b0, r_count} + ((r_s1_pix | r_s1_flush) ? (AW+2)'(2) : '0) + (AW+2)'(2);
    assign s_axis_tready = (need <= (AW+2)'(nmf_pkg::FIFO_DEPTH));

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_fifo[r_rd_ptr].idx;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

endmodule

`default_nettype wire
